### hdl/exact_byte_pattern_matcher_unit_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the exact byte pattern matcher
// Shared helpers for the concurrent checks at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef EXACT_BYTE_PATTERN_MATCHER_UNIT_MACROS_SVH
`define EXACT_BYTE_PATTERN_MATCHER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define EPM_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("epm: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define EPM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("epm: next-cycle check failed");

`endif

### hdl/epm_pkg.sv
// ---------------------------------------------------------------------------
// epm_pkg
// Constants, register codes and shared types of the byte pattern matcher.
// ---------------------------------------------------------------------------
package epm_pkg;

    // Needle register capacity in bytes (two 64-bit registers)
    localparam int NEEDLE_REG_BYTES = 16;

    // Field widths
    localparam int LEN_W       = 5;
    localparam int INDEX_W     = 32;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_NEEDLE_LOW    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_NEEDLE_HIGH   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_NEEDLE_LENGTH = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_START_INDEX   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_END_INDEX     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_END_LIMIT_ON  = 3'd5;

    // Per-beat control handed to the cells and the position counter
    typedef struct packed {
        logic advance;   // an input beat is taken this cycle
        logic restart;   // that beat is the last of its sequence
    } t_step_ctrl;

endpackage

### hdl/epm_if.sv
// ---------------------------------------------------------------------------
// epm_if
// Valid/ready channels of the matcher: byte input, result output, config.
// ---------------------------------------------------------------------------
interface epm_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface epm_out_if;
    logic                        valid;
    logic                        ready;
    logic                        match_found;
    logic [epm_pkg::INDEX_W-1:0] match_start;
    logic                        sequence_end;

    modport source (output valid, output match_found, output match_start,
                    output sequence_end, input ready);
    modport sink   (input valid, input match_found, input match_start,
                    input sequence_end, output ready);
endinterface

interface epm_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [epm_pkg::CFG_INDEX_W-1:0] index;
    logic [epm_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### hdl/epm_cell.sv
// ---------------------------------------------------------------------------
// epm_cell
// One window cell: holds one recent byte, hands it to the next cell on every
// taken beat and compares the byte at its place with the aligned needle byte.
// ---------------------------------------------------------------------------
module epm_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  epm_pkg::t_step_ctrl i_ctrl,
    input  logic [7:0]          i_byte,
    input  logic [7:0]          i_needle_byte,
    input  logic                i_active,
    output logic [7:0]          o_byte,
    output logic                o_ok
);

    logic [7:0] r_byte;

    // Byte at this place of the window, shifted on; cleared after the last beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte <= 8'h00;
        end else if (i_ctrl.advance) begin
            r_byte <= i_ctrl.restart ? 8'h00 : i_byte;
        end
    end

    // Places beyond the needle length do not take part
    assign o_ok   = !i_active || (i_byte == i_needle_byte);
    assign o_byte = r_byte;

endmodule

### hdl/epm_position.sv
// ---------------------------------------------------------------------------
// epm_position
// Saturating index of the next byte; back to zero after the last beat.
// ---------------------------------------------------------------------------
module epm_position #(
    parameter int POSITION_WIDTH = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  epm_pkg::t_step_ctrl       i_ctrl,
    output logic [POSITION_WIDTH-1:0] o_pos
);

    logic [POSITION_WIDTH-1:0] r_pos;
    logic [POSITION_WIDTH-1:0] n_pos;

    // Stop at all ones, restart at sequence end
    always_comb begin
        if (i_ctrl.restart) begin
            n_pos = '0;
        end else if (&r_pos) begin
            n_pos = r_pos;
        end else begin
            n_pos = r_pos + POSITION_WIDTH'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (i_ctrl.advance) begin
            r_pos <= n_pos;
        end
    end

    assign o_pos = r_pos;

endmodule

### hdl/exact_byte_pattern_matcher_unit.sv
// ---------------------------------------------------------------------------
// exact_byte_pattern_matcher_unit
// Reports every (overlapping) occurrence of a configured needle in a byte
// stream, one result beat per input byte.
// ---------------------------------------------------------------------------
// Usage:
//   i_in   : one byte per beat, last_byte marks the final byte of a sequence.
//   o_out  : one result beat per input beat, in order. match_found is set
//            when the needle ends on that byte inside the start/end window;
//            match_start then gives the index of its first byte.
//            sequence_end echoes last_byte.
//   i_cfg  : register writes (needle, length, window); always ready, and
//            only to be used while no beat is in flight.
// Results follow in the cycle after their input beat; throughput is one byte
// per cycle unless stalled, set by the row of byte cells compared in parallel
// with the needle and the window compare that feeds the output register.
// Reset clears the cells, the position counter and the output valid flag and
// loads the register defaults (length 1, end limit off).
// When the receiver stalls, the result stays in the output register and the
// input is held off until it is taken; nothing is dropped.
// ---------------------------------------------------------------------------
`include "exact_byte_pattern_matcher_unit_macros.svh"

module exact_byte_pattern_matcher_unit #(
    parameter int MAX_NEEDLE     = 16,
    parameter int POSITION_WIDTH = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    epm_in_if.sink         i_in,
    epm_cfg_if.sink        i_cfg,
    epm_out_if.source      o_out
);

    localparam int NCELL = (MAX_NEEDLE < epm_pkg::NEEDLE_REG_BYTES)
                         ? MAX_NEEDLE : epm_pkg::NEEDLE_REG_BYTES;
    localparam int SELW  = (NCELL > 1) ? $clog2(NCELL) : 1;
    localparam int CW    = (POSITION_WIDTH > epm_pkg::INDEX_W)
                         ? POSITION_WIDTH : epm_pkg::INDEX_W;

    // Configuration registers
    logic [63:0]                 r_needle_low;
    logic [63:0]                 r_needle_high;
    logic [epm_pkg::LEN_W-1:0]   r_needle_length;
    logic [epm_pkg::INDEX_W-1:0] r_start_index;
    logic [epm_pkg::INDEX_W-1:0] r_end_index;
    logic                        r_end_limit_on;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_needle_low    <= '0;
            r_needle_high   <= '0;
            r_needle_length <= epm_pkg::LEN_W'(1);
            r_start_index   <= '0;
            r_end_index     <= '1;
            r_end_limit_on  <= 1'b0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                epm_pkg::REG_NEEDLE_LOW:    r_needle_low    <= i_cfg.data;
                epm_pkg::REG_NEEDLE_HIGH:   r_needle_high   <= i_cfg.data;
                epm_pkg::REG_NEEDLE_LENGTH: r_needle_length <= i_cfg.data[epm_pkg::LEN_W-1:0];
                epm_pkg::REG_START_INDEX:   r_start_index   <= i_cfg.data[epm_pkg::INDEX_W-1:0];
                epm_pkg::REG_END_INDEX:     r_end_index     <= i_cfg.data[epm_pkg::INDEX_W-1:0];
                epm_pkg::REG_END_LIMIT_ON:  r_end_limit_on  <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    // Handshake and per-beat control
    logic                r_valid;
    logic                w_in_ready;
    epm_pkg::t_step_ctrl w_ctrl;

    assign w_in_ready     = !r_valid || o_out.ready;
    assign i_in.ready     = w_in_ready;
    assign w_ctrl.advance = i_in.valid && w_in_ready;
    assign w_ctrl.restart = i_in.last_byte;

    // Needle length in use
    logic [epm_pkg::LEN_W-1:0]  w_len_m1;
    logic                       w_len_ok;

    assign w_len_m1    = r_needle_length - epm_pkg::LEN_W'(1);
    assign w_len_ok    = (r_needle_length != '0)
                      && (r_needle_length <= epm_pkg::LEN_W'(NCELL));

    // Row of byte cells; place k of the window is the byte k beats back,
    // compared with needle byte length-1-k
    logic [NCELL:0][7:0]   w_chain;
    logic [NCELL-1:0][7:0] w_needle;
    logic [NCELL-1:0]      w_ok;

    assign w_chain[0] = i_in.data_byte;

    genvar k;
    generate
        for (k = 0; k < NCELL; k++) begin : g_cell
            logic [epm_pkg::LEN_W-1:0] w_idx;
            logic                      w_active;

            if (k < 8) begin : g_lo
                assign w_needle[k] = r_needle_low[8*k +: 8];
            end else begin : g_hi
                assign w_needle[k] = r_needle_high[8*(k-8) +: 8];
            end

            assign w_idx    = w_len_m1 - epm_pkg::LEN_W'(k);
            assign w_active = (epm_pkg::LEN_W'(k) <= w_len_m1);

            epm_cell u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_ctrl        (w_ctrl),
                .i_byte        (w_chain[k]),
                .i_needle_byte (w_needle[w_idx[SELW-1:0]]),
                .i_active      (w_active),
                .o_byte        (w_chain[k+1]),
                .o_ok          (w_ok[k])
            );
        end
    endgenerate

    // Position of the current byte
    logic [POSITION_WIDTH-1:0] w_pos;

    epm_position #(
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_position (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_ctrl),
        .o_pos   (w_pos)
    );

    // Enough bytes of this sequence, needle equal, and inside the window
    logic                       w_all_eq;
    logic                       w_enough;
    logic [POSITION_WIDTH-1:0]  w_first;
    logic [CW-1:0]              w_first_cw;
    logic [CW-1:0]              w_pos_cw;
    logic                       w_in_window;
    logic                       w_found;

    assign w_all_eq    = &w_ok;
    assign w_pos_cw    = CW'(w_pos);
    assign w_enough    = (w_pos_cw >= CW'(w_len_m1));
    assign w_first     = w_pos - POSITION_WIDTH'(w_len_m1);
    assign w_first_cw  = CW'(w_first);
    assign w_in_window = (w_first_cw >= CW'(r_start_index))
                      && (!r_end_limit_on || (w_pos_cw < CW'(r_end_index)));
    assign w_found     = w_len_ok && w_enough && w_all_eq && w_in_window;

    // Output register
    logic                        r_match_found;
    logic [epm_pkg::INDEX_W-1:0] r_match_start;
    logic                        r_sequence_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_in_ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.advance) begin
            r_match_found  <= w_found;
            r_match_start  <= w_found ? w_first_cw[epm_pkg::INDEX_W-1:0] : '0;
            r_sequence_end <= i_in.last_byte;
        end
    end

    assign o_out.valid        = r_valid;
    assign o_out.match_found  = r_match_found;
    assign o_out.match_start  = r_match_start;
    assign o_out.sequence_end = r_sequence_end;

    // Checks
    `EPM_ASSERT_NEXT(a_beat_gives_result, i_clk, i_rst_n, w_ctrl.advance, r_valid)
    `EPM_ASSERT_NEXT(a_last_restarts_pos, i_clk, i_rst_n, w_ctrl.advance && w_ctrl.restart, w_pos == '0)
    `EPM_ASSERT_NEXT(a_last_clears_row, i_clk, i_rst_n, w_ctrl.advance && w_ctrl.restart, w_chain[NCELL] == 8'h00)
    `EPM_ASSERT_IMPLIES(a_no_match_zero_start, i_clk, i_rst_n, r_valid && !r_match_found, r_match_start == '0)

endmodule
